/* hdl/iss_pkg.sv */
// Package for the interval set subtract block: payload structs, command codes,
// overlap classes and default table depth. No dependencies.
`timescale 1ns / 1ps

package iss_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic [1:0] CMD_CLEAR    = 2'd0;
    localparam logic [1:0] CMD_APPEND   = 2'd1;
    localparam logic [1:0] CMD_SUBTRACT = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } t_in;

    typedef struct packed {
        logic signed [31:0] piece_low;
        logic signed [31:0] piece_high;
        logic               piece_present;
        logic               order_error;
        logic               last;
    } t_out;

    typedef enum logic [2:0] {
        OVL_NONE,
        OVL_FULL,
        OVL_LEFT,
        OVL_RIGHT,
        OVL_CONT,
        OVL_BAD
    } t_ovl;

    typedef struct packed {
        t_ovl               ovl;
        logic signed [31:0] start_m1;
        logic signed [31:0] end_p1;
    } t_cls;

endpackage

/* hdl/interval_set_subtract.sv */
// Top level: removal table, walk sequencer and output register.
// Depends on iss_pkg, iss_ram and iss_cmp.
//
//  port group   dir  handshake              payload
//  in           in   i_in_valid/o_in_stall  i_in_data  (t_in)
//  out          out  o_out_valid/i_out_stall o_out_data (t_out)
//
// Clear and append are handled in the idle state. Subtract walks the table up to
// twice through one classifier, each entry per pass taking a RAM read state, then a
// classify state; the output side can stall the classify state. The first pass checks
// order and counts pieces, the second emits them. Reset empties the table and
// drops any pending result. Input is stalled for the whole subtract walk.
`timescale 1ns / 1ps

module interval_set_subtract
    import iss_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = $clog2(TABLE_DEPTH + 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_FIN
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic [NW-1:0]      r_n, n_n;
    logic [NW-1:0]      r_k, n_k;
    logic               r_pass, n_pass;
    logic               r_err, n_err;
    logic               r_alive, n_alive;
    logic signed [31:0] r_lo, n_lo;
    logic signed [31:0] r_hi, n_hi;
    logic signed [31:0] r_cl, n_cl;
    logic signed [31:0] r_ch, n_ch;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;

    logic               ram_we;
    logic [63:0]        ram_rdata;
    logic signed [31:0] ent_start;
    logic signed [31:0] ent_end;
    t_cls               cls;
    logic               slot_free;
    logic               piece;

    iss_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_in_data.range_low, i_in_data.range_high}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign ent_start = ram_rdata[63:32];
    assign ent_end   = ram_rdata[31:0];

    iss_cmp u_cmp (
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .i_cl    (r_cl),
        .i_ch    (r_ch),
        .i_alive (r_alive),
        .i_start (ent_start),
        .i_end   (ent_end),
        .o_cls   (cls)
    );

    assign slot_free = !r_out_valid || !i_out_stall;
    assign piece     = cls.ovl == OVL_LEFT || cls.ovl == OVL_CONT;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_n         = r_n;
        n_k         = r_k;
        n_pass      = r_pass;
        n_err       = r_err;
        n_alive     = r_alive;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_cl        = r_cl;
        n_ch        = r_ch;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        ram_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.cmd == CMD_CLEAR) begin
                        n_count = '0;
                    end else if (i_in_data.cmd == CMD_APPEND) begin
                        if (r_count < CW'(TABLE_DEPTH)) begin
                            ram_we  = 1'b1;
                            n_count = CW'(r_count + 1'b1);
                        end
                    end else if (i_in_data.cmd == CMD_SUBTRACT) begin
                        n_lo    = i_in_data.range_low;
                        n_hi    = i_in_data.range_high;
                        n_cl    = i_in_data.range_low;
                        n_ch    = i_in_data.range_high;
                        n_alive = 1'b1;
                        n_pass  = 1'b0;
                        n_err   = 1'b0;
                        n_n     = '0;
                        n_k     = '0;
                        n_idx   = '0;
                        n_state = (r_count == '0) ? S_FIN : S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (cls.ovl == OVL_BAD) begin
                    n_err   = 1'b1;
                    n_state = S_FIN;
                end else if (cls.ovl == OVL_FULL) begin
                    n_alive = 1'b0;
                    n_state = S_FIN;
                end else if (!(r_pass && piece && !slot_free)) begin
                    if (piece) begin
                        if (r_pass) begin
                            n_out_valid         = 1'b1;
                            n_out.piece_low     = r_cl;
                            n_out.piece_high    = cls.start_m1;
                            n_out.piece_present = 1'b1;
                            n_out.order_error   = 1'b0;
                            n_out.last          = NW'(r_k + 1'b1) == r_n;
                            n_k                 = NW'(r_k + 1'b1);
                        end else begin
                            n_n = NW'(r_n + 1'b1);
                        end
                    end
                    if (cls.ovl == OVL_LEFT) begin
                        n_alive = 1'b0;
                    end
                    if (cls.ovl == OVL_RIGHT || cls.ovl == OVL_CONT) begin
                        n_cl = cls.end_p1;
                    end
                    n_idx   = CW'(r_idx + 1'b1);
                    n_state = (CW'(r_idx + 1'b1) == r_count) ? S_FIN : S_RD;
                end
            end
            S_FIN: begin
                if (!r_pass) begin
                    if (r_err) begin
                        if (slot_free) begin
                            n_out_valid = 1'b1;
                            n_out       = '{piece_low: '0, piece_high: '0, piece_present: 1'b0,
                                            order_error: 1'b1, last: 1'b1};
                            n_state     = S_IDLE;
                        end
                    end else begin
                        n_n     = NW'(r_n + NW'(r_alive));
                        n_pass  = 1'b1;
                        n_cl    = r_lo;
                        n_ch    = r_hi;
                        n_alive = 1'b1;
                        n_idx   = '0;
                        n_state = (r_count == '0) ? S_FIN : S_RD;
                    end
                end else if (r_n == '0) begin
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '{piece_low: '0, piece_high: '0, piece_present: 1'b0,
                                        order_error: 1'b0, last: 1'b1};
                        n_state     = S_IDLE;
                    end
                end else if (r_alive) begin
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '{piece_low: r_cl, piece_high: r_ch, piece_present: 1'b1,
                                        order_error: 1'b0, last: 1'b1};
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_pass      <= 1'b0;
            r_err       <= 1'b0;
            r_alive     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_k         <= n_k;
            r_pass      <= n_pass;
            r_err       <= n_err;
            r_alive     <= n_alive;
            r_out_valid <= n_out_valid;
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_cl  <= n_cl;
        r_ch  <= n_ch;
        r_out <= n_out;
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hdl/iss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module iss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/iss_cmp.sv */
// Overlap classifier: compares one removal entry against the command range and
// the remaining range. Depends on iss_pkg.
`timescale 1ns / 1ps

module iss_cmp
    import iss_pkg::*;
(
    input  logic signed [31:0] i_lo,
    input  logic signed [31:0] i_hi,
    input  logic signed [31:0] i_cl,
    input  logic signed [31:0] i_ch,
    input  logic               i_alive,
    input  logic signed [31:0] i_start,
    input  logic signed [31:0] i_end,
    output t_cls               o_cls
);

    logic rel;
    logic full;
    logic left;
    logic right;
    logic cont;

    assign rel = (i_lo <= i_start && i_start <= i_hi) ||
                 (i_lo <= i_end && i_end <= i_hi) ||
                 (i_start <= i_lo && i_lo <= i_end);
    assign full  = i_start <= i_cl && i_cl <= i_end && i_start <= i_ch && i_ch <= i_end;
    assign left  = i_cl < i_start && i_start <= i_ch && i_ch <= i_end;
    assign right = i_start <= i_cl && i_cl <= i_end && i_end < i_ch;
    assign cont  = i_cl < i_start && i_start < i_ch && i_cl < i_end && i_end < i_ch;

    always_comb begin
        o_cls.start_m1 = i_start - 32'sd1;
        o_cls.end_p1   = i_end + 32'sd1;
        priority if (!rel) begin
            o_cls.ovl = OVL_NONE;
        end else if (!i_alive) begin
            o_cls.ovl = OVL_BAD;
        end else if (full) begin
            o_cls.ovl = OVL_FULL;
        end else if (left) begin
            o_cls.ovl = OVL_LEFT;
        end else if (right) begin
            o_cls.ovl = OVL_RIGHT;
        end else if (cont) begin
            o_cls.ovl = OVL_CONT;
        end else begin
            o_cls.ovl = OVL_BAD;
        end
    end

endmodule

/* hdl/iss_chk.sv */
// Port-level checker for interval_set_subtract, bound to the top level.
// Depends on iss_pkg.
`timescale 1ns / 1ps

module iss_chk
    import iss_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_stall,
    input t_in  i_in_data,
    input logic i_out_valid,
    input logic i_out_stall,
    input t_out i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    a_subtract_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall && i_in_data.cmd == CMD_SUBTRACT |=> i_in_stall)
        else $error("subtract transfer not followed by busy");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.piece_present |->
            i_out_data.last && i_out_data.piece_low == '0 && i_out_data.piece_high == '0)
        else $error("result without piece is not a zeroed final result");

    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.order_error |-> !i_out_data.piece_present)
        else $error("order error carries a piece");

endmodule

bind interval_set_subtract iss_chk u_iss_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
